// ===== rtl/kwm_pkg.sv =====
package kwm_pkg;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_MERGE = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [1:0]        list_id;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] merged_value;
        logic               last;
        logic               empty_res;
        logic               overflow;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREFETCH,
        ST_MERGE,
        ST_EMPTY
    } t_state;

endpackage

// ===== rtl/kwm_select.sv =====
module kwm_select #(
    parameter int NUM_LISTS = 4,
    localparam int LW = $clog2(NUM_LISTS)
) (
    input  logic signed [31:0]   i_heads [NUM_LISTS],
    input  logic [NUM_LISTS-1:0] i_valid,
    output logic                 o_any,
    output logic [LW-1:0]        o_win,
    output logic signed [31:0]   o_value
);

    // Ascending scan with a non-strict compare, so the highest list wins a tie.
    always_comb begin
        o_any   = 1'b0;
        o_win   = '0;
        o_value = '0;
        for (int j = 0; j < NUM_LISTS; j++) begin
            if (i_valid[j] && (!o_any || i_heads[j] <= o_value)) begin
                o_any   = 1'b1;
                o_win   = LW'(j);
                o_value = i_heads[j];
            end
        end
    end

endmodule

// ===== rtl/k_way_sorted_merge.sv =====
// K-way merge of ascending lists held in one shared list memory.
// Command channel: an item is taken at a rising edge with i_start high and
// o_busy low. A load item (kind low) appends its value to list list_id;
// loads may follow back to back. A load into a full or an inactive list
// is dropped and sets the sticky overflow flag.
// A merge item first reads the head of every list out of the memory, one
// list per cycle, and then emits one result per cycle, each on o_result
// for one cycle with o_strobe high, the smallest head first. The memory
// read of the winner's next element is forwarded into the next compare,
// so the read port sustains one result per cycle. A merge holds o_busy
// high until its last result; a merge with nothing stored gives one
// empty result in the cycle after it was taken.
// The last result carries last; afterwards lists and flag are cleared.
// Results cannot be stalled: the receiver must take each one as it appears.
// The active list count is written through the cfg channel while idle.
// Reset clears fill counts, read positions and the flag, and sets the
// active count to four; the list memory itself is not cleared.
module k_way_sorted_merge #(
    parameter int NUM_LISTS  = 4,
    parameter int LIST_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  kwm_pkg::t_in_item   i_item,
    output logic                o_strobe,
    output kwm_pkg::t_out_item  o_result,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_data
);

    localparam int LW  = $clog2(NUM_LISTS);
    localparam int CW  = $clog2(LIST_DEPTH + 1);
    localparam int AW  = (NUM_LISTS * LIST_DEPTH > 1) ? $clog2(NUM_LISTS * LIST_DEPTH) : 1;
    localparam int IDW = (LW > 2) ? LW : 2;
    localparam int MD  = NUM_LISTS * LIST_DEPTH;

    kwm_pkg::t_state r_state, n_state;

    logic [2:0]           r_active;
    logic                 r_dropped;
    logic [CW-1:0]        r_count [NUM_LISTS];
    logic [CW-1:0]        r_pos   [NUM_LISTS];
    logic                 r_pend;
    logic [LW-1:0]        r_pend_id;
    logic [LW-1:0]        r_k;
    logic signed [31:0]   r_head  [NUM_LISTS];
    logic signed [31:0]   r_mem   [MD];
    logic signed [31:0]   r_mem_q;

    logic [2:0]           act_sat;
    logic [NUM_LISTS-1:0] act_mask;
    logic [NUM_LISTS-1:0] valid;
    logic                 any_stored;
    logic signed [31:0]   head_eff [NUM_LISTS];
    logic                 sel_any;
    logic [LW-1:0]        sel_win;
    logic signed [31:0]   sel_val;
    logic [CW-1:0]        pos_next;
    logic                 more;
    logic                 others;
    logic                 last_merge;
    logic                 accept;
    logic [IDW-1:0]       id_x;
    logic [LW-1:0]        id_ix;
    logic                 load_ok;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [LW-1:0]        mem_rid;

    assign accept      = i_start && !o_busy;
    assign o_cfg_ready = (r_state == kwm_pkg::ST_IDLE);

    assign act_sat = ({1'b0, r_active} > 4'(NUM_LISTS)) ? 3'(NUM_LISTS) : r_active;

    always_comb begin
        any_stored = 1'b0;
        for (int j = 0; j < NUM_LISTS; j++) begin
            act_mask[j] = 4'(j) < {1'b0, act_sat};
            valid[j]    = act_mask[j] && (r_pos[j] < r_count[j]);
            any_stored  = any_stored || (act_mask[j] && (r_count[j] != '0));
            // A head read issued last cycle is taken straight from the memory output.
            head_eff[j] = (r_pend && r_pend_id == LW'(j)) ? r_mem_q : r_head[j];
        end
    end

    kwm_select #(
        .NUM_LISTS (NUM_LISTS)
    ) u_select (
        .i_heads (head_eff),
        .i_valid (valid),
        .o_any   (sel_any),
        .o_win   (sel_win),
        .o_value (sel_val)
    );

    always_comb begin
        pos_next   = CW'(r_pos[sel_win] + 1'b1);
        more       = pos_next < r_count[sel_win];
        others     = |(valid & ~(NUM_LISTS'(1) << sel_win));
        last_merge = !more && !others;
    end

    assign id_x    = IDW'(i_item.list_id);
    assign id_ix   = id_x[LW-1:0];
    assign load_ok = ({1'b0, i_item.list_id} < act_sat) &&
                     (r_count[id_ix] < CW'(LIST_DEPTH));

    assign mem_we    = accept && (i_item.kind == kwm_pkg::KIND_LOAD) && load_ok;
    assign mem_waddr = AW'(id_ix * LIST_DEPTH) + AW'(r_count[id_ix]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            kwm_pkg::ST_IDLE: begin
                if (accept && i_item.kind == kwm_pkg::KIND_MERGE) begin
                    n_state = any_stored ? kwm_pkg::ST_PREFETCH : kwm_pkg::ST_EMPTY;
                end
            end
            kwm_pkg::ST_PREFETCH: begin
                if (r_k == LW'(NUM_LISTS - 1)) begin
                    n_state = kwm_pkg::ST_MERGE;
                end
            end
            kwm_pkg::ST_MERGE: begin
                if (!sel_any || last_merge) begin
                    n_state = kwm_pkg::ST_IDLE;
                end
            end
            kwm_pkg::ST_EMPTY: n_state = kwm_pkg::ST_IDLE;
            default:           n_state = kwm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy    = 1'b1;
        o_strobe  = 1'b0;
        o_result  = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        mem_rid   = '0;
        case (r_state)
            kwm_pkg::ST_IDLE: o_busy = 1'b0;
            kwm_pkg::ST_PREFETCH: begin
                mem_re    = 1'b1;
                mem_raddr = AW'(r_k * LIST_DEPTH);
                mem_rid   = r_k;
            end
            kwm_pkg::ST_MERGE: begin
                o_strobe              = sel_any;
                o_result.merged_value = sel_val;
                o_result.last         = last_merge;
                o_result.overflow     = r_dropped;
                if (sel_any && more) begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(sel_win * LIST_DEPTH) + AW'(pos_next);
                    mem_rid   = sel_win;
                end
            end
            kwm_pkg::ST_EMPTY: begin
                o_strobe           = 1'b1;
                o_result.last      = 1'b1;
                o_result.empty_res = 1'b1;
                o_result.overflow  = r_dropped;
            end
            default: o_busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kwm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 3'd4;
            r_dropped <= 1'b0;
            r_pend    <= 1'b0;
            r_k       <= '0;
            for (int j = 0; j < NUM_LISTS; j++) begin
                r_count[j] <= '0;
                r_pos[j]   <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_active <= i_cfg_data;
            end
            r_pend <= mem_re;
            case (r_state)
                kwm_pkg::ST_IDLE: begin
                    r_k <= '0;
                    if (accept && i_item.kind == kwm_pkg::KIND_LOAD) begin
                        if (load_ok) begin
                            r_count[id_ix] <= CW'(r_count[id_ix] + 1'b1);
                        end else begin
                            r_dropped <= 1'b1;
                        end
                    end
                end
                kwm_pkg::ST_PREFETCH: r_k <= LW'(r_k + 1'b1);
                kwm_pkg::ST_MERGE: begin
                    if (sel_any) begin
                        r_pos[sel_win] <= pos_next;
                    end
                    if (!sel_any || last_merge) begin
                        r_dropped <= 1'b0;
                        for (int j = 0; j < NUM_LISTS; j++) begin
                            r_count[j] <= '0;
                            r_pos[j]   <= '0;
                        end
                    end
                end
                kwm_pkg::ST_EMPTY: begin
                    r_dropped <= 1'b0;
                    for (int j = 0; j < NUM_LISTS; j++) begin
                        r_count[j] <= '0;
                        r_pos[j]   <= '0;
                    end
                end
                default: r_k <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= i_item.value;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_raddr];
        end
        r_pend_id <= mem_rid;
        if (r_pend) begin
            r_head[r_pend_id] <= r_mem_q;
        end
    end

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_busy)
        else $error("result strobe outside a merge");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.empty_res |-> o_result.last)
        else $error("empty result not marked last");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |=> !o_busy)
        else $error("block still busy after the last result");

    a_merge_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == kwm_pkg::ST_MERGE |-> sel_any)
        else $error("merge step without any unread list");

    a_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |=> !r_dropped)
        else $error("overflow flag not cleared after a merge");

endmodule
